>>> rtl/assert_macros.svh
// Assertion macros used by srsw_seq.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SRSW_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Implication checked in the same cycle.
`define SRSW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/srsw_pkg.sv
package srsw_pkg;

  localparam int CntW  = 13;
  localparam int PageW = 12;
  localparam int LimW  = 7;

  localparam logic [1:0] CfgPageCount  = 2'd0;
  localparam logic [1:0] CfgBurstLimit = 2'd1;

  localparam logic ReqBurst = 1'b0;
  localparam logic ReqAck   = 1'b1;

  localparam logic [1:0] AckOther = 2'd0;
  localparam logic [1:0] AckPage  = 2'd1;
  localparam logic [1:0] AckEot   = 2'd2;

  typedef struct packed {
    logic             req_type;
    logic [1:0]       ack_kind;
    logic [PageW-1:0] ack_page;
  } in_t;

  typedef struct packed {
    logic [PageW-1:0] send_page;
    logic             send_valid;
    logic             last_in_run;
    logic [CntW-1:0]  contiguous_acked;
    logic [CntW-1:0]  pages_remaining;
    logic             transfer_done;
    logic             eot_seen;
  } out_t;

  typedef struct packed {
    logic [CntW-1:0] page_count;
    logic [LimW-1:0] burst_lim;
    logic            pc_wr;
    logic [CntW-1:0] pc_wdata;
  } cfg_t;

  typedef enum logic {
    AluInc,
    AluDec
  } alu_op_e;

  typedef struct packed {
    alu_op_e         op;
    logic [CntW-1:0] a;
    logic [CntW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [CntW-1:0] res;
    logic            lt;
  } alu_rsp_t;

endpackage

>>> rtl/srsw_ram.sv
module srsw_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/srsw_alu.sv
module srsw_alu (
  input  srsw_pkg::alu_req_t req_i,
  output srsw_pkg::alu_rsp_t rsp_o
);

  logic [srsw_pkg::CntW-1:0] step;

  always_comb begin
    unique case (req_i.op)
      srsw_pkg::AluInc: step = srsw_pkg::CntW'(1);
      srsw_pkg::AluDec: step = '1;
      default:          step = srsw_pkg::CntW'(1);
    endcase
    rsp_o.res = req_i.a + step;
    rsp_o.lt  = (req_i.a < req_i.b);
  end

endmodule

>>> rtl/srsw_seq.sv
`include "assert_macros.svh"

module srsw_seq #(
  parameter int MAX_PAGES = 4096,
  localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srsw_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  srsw_pkg::in_t      in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output srsw_pkg::out_t     out_o,
  output srsw_pkg::alu_req_t alu_req_o,
  input  srsw_pkg::alu_rsp_t alu_rsp_i,
  output logic               ram_we_o,
  output logic [AW-1:0]      ram_waddr_o,
  output logic               ram_wdata_o,
  output logic               ram_re_o,
  output logic [AW-1:0]      ram_raddr_o,
  input  logic               ram_rdata_i
);

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StAckRange,
    StAckRd,
    StScanCmp,
    StScanRd,
    StAckOut,
    StBInit,
    StBCmp,
    StBRd,
    StBEnd
  } state_e;

  localparam logic [AW-1:0] ClrLast = AW'(MAX_PAGES - 1);

  state_e                     state_q;
  logic [AW-1:0]              clr_q;
  logic [srsw_pkg::CntW-1:0]  ptr_q;
  logic [srsw_pkg::CntW-1:0]  remaining_q;
  logic                       eot_q;
  logic [srsw_pkg::CntW-1:0]  scan_q;
  logic [srsw_pkg::LimW-1:0]  left_q;
  logic [srsw_pkg::PageW-1:0] pend_q;
  logic                       pend_v_q;
  srsw_pkg::in_t              item_q;
  logic                       out_valid_q;
  srsw_pkg::out_t             out_q;

  logic           out_free;
  logic           out_load;
  srsw_pkg::out_t res_stat;
  srsw_pkg::out_t res_mid;
  srsw_pkg::out_t res_last;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle) && !cfg_i.pc_wr;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign out_load    = !cfg_i.pc_wr && out_free &&
                       ((state_q == StAckOut) || (state_q == StBEnd) ||
                        ((state_q == StBRd) && !ram_rdata_i && pend_v_q));

  always_comb begin
    alu_req_o.op = srsw_pkg::AluInc;
    alu_req_o.a  = ptr_q;
    alu_req_o.b  = cfg_i.page_count;
    unique case (state_q)
      StAckRange: alu_req_o.a = {1'b0, item_q.ack_page};
      StAckRd: begin
        alu_req_o.op = srsw_pkg::AluDec;
        alu_req_o.a  = remaining_q;
      end
      StBInit: begin
        alu_req_o.a = remaining_q;
        alu_req_o.b = {{(srsw_pkg::CntW - srsw_pkg::LimW){1'b0}}, cfg_i.burst_lim};
      end
      StBCmp, StBRd: alu_req_o.a = scan_q;
      default: ;
    endcase
  end

  always_comb begin
    ram_re_o    = alu_rsp_i.lt && ((state_q == StAckRange) || (state_q == StScanCmp) ||
                  ((state_q == StBCmp) && (left_q != '0)));
    ram_raddr_o = AW'(alu_req_o.a);
    ram_we_o    = 1'b0;
    ram_waddr_o = clr_q;
    ram_wdata_o = 1'b0;
    if (state_q == StClear) begin
      ram_we_o = 1'b1;
    end else if ((state_q == StAckRd) && !ram_rdata_i) begin
      ram_we_o    = 1'b1;
      ram_waddr_o = AW'(item_q.ack_page);
      ram_wdata_o = 1'b1;
    end
  end

  always_comb begin
    res_stat.send_page        = '0;
    res_stat.send_valid       = 1'b0;
    res_stat.last_in_run      = 1'b1;
    res_stat.contiguous_acked = ptr_q;
    res_stat.pages_remaining  = remaining_q;
    res_stat.transfer_done    = (remaining_q == '0) && (ptr_q == cfg_i.page_count);
    res_stat.eot_seen         = eot_q;
    res_mid             = res_stat;
    res_mid.send_page   = pend_q;
    res_mid.send_valid  = 1'b1;
    res_mid.last_in_run = 1'b0;
    res_last             = res_mid;
    res_last.last_in_run = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      ptr_q       <= '0;
      remaining_q <= '0;
      eot_q       <= 1'b0;
      scan_q      <= '0;
      left_q      <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.pc_wr) begin
        state_q     <= StClear;
        clr_q       <= '0;
        ptr_q       <= '0;
        remaining_q <= cfg_i.pc_wdata;
        eot_q       <= 1'b0;
        pend_v_q    <= 1'b0;
      end else begin
        unique case (state_q)
          StClear: begin
            clr_q <= clr_q + AW'(1);
            if (clr_q == ClrLast) begin
              state_q <= StIdle;
            end
          end
          StIdle: begin
            if (in_valid_i) begin
              item_q <= in_i;
              if (in_i.req_type == srsw_pkg::ReqAck) begin
                if (in_i.ack_kind == srsw_pkg::AckPage) begin
                  state_q <= StAckRange;
                end else begin
                  if (in_i.ack_kind == srsw_pkg::AckEot) begin
                    eot_q <= 1'b1;
                  end
                  state_q <= StScanCmp;
                end
              end else begin
                state_q <= StBInit;
              end
            end
          end
          StAckRange: begin
            state_q <= alu_rsp_i.lt ? StAckRd : StScanCmp;
          end
          StAckRd: begin
            if (!ram_rdata_i && (remaining_q != '0)) begin
              remaining_q <= alu_rsp_i.res;
            end
            state_q <= StScanCmp;
          end
          StScanCmp: begin
            state_q <= alu_rsp_i.lt ? StScanRd : StAckOut;
          end
          StScanRd: begin
            if (ram_rdata_i) begin
              ptr_q   <= alu_rsp_i.res;
              state_q <= StScanCmp;
            end else begin
              state_q <= StAckOut;
            end
          end
          StAckOut: begin
            if (out_free) begin
              out_q   <= res_stat;
              state_q <= StIdle;
            end
          end
          StBInit: begin
            left_q  <= alu_rsp_i.lt ? remaining_q[srsw_pkg::LimW-1:0] : cfg_i.burst_lim;
            scan_q  <= ptr_q;
            state_q <= StBCmp;
          end
          StBCmp: begin
            state_q <= (alu_rsp_i.lt && (left_q != '0)) ? StBRd : StBEnd;
          end
          StBRd: begin
            if (ram_rdata_i) begin
              scan_q  <= alu_rsp_i.res;
              state_q <= StBCmp;
            end else if (!pend_v_q || out_free) begin
              if (pend_v_q) begin
                out_q <= res_mid;
              end
              pend_q   <= scan_q[srsw_pkg::PageW-1:0];
              pend_v_q <= 1'b1;
              left_q   <= left_q - srsw_pkg::LimW'(1);
              scan_q   <= alu_rsp_i.res;
              state_q  <= StBCmp;
            end
          end
          StBEnd: begin
            if (out_free) begin
              out_q    <= pend_v_q ? res_last : res_stat;
              pend_v_q <= 1'b0;
              state_q  <= StIdle;
            end
          end
          default: state_q <= StIdle;
        endcase
      end
    end
  end

  `SRSW_ASSERT(a_ptr_bound, ptr_q <= cfg_i.page_count, "contiguous pointer passed page count")
  `SRSW_ASSERT(a_rem_bound, remaining_q <= cfg_i.page_count, "remaining count above page count")
  `SRSW_ASSERT_IMPL(a_idle_no_pend, state_q == StIdle, !pend_v_q, "pending page left after burst")

endmodule

>>> rtl/selective_repeat_sender_window_unit.sv
// Selective-repeat sender window: ack bitmap, contiguous pointer and remaining count.
// Input channel (in_valid_i/in_ready_o, in_i) takes one item per transaction: either
// an acknowledgement (page ack, end-of-transmission marker or other reply) or a burst
// request. Results leave on out_valid_o/out_ready_i as out_o, one per ack item and
// one or more per burst request, the final one flagged by last_in_run.
// Configuration writes (cfg_valid_i, cfg_index_i, cfg_data_i) are always ready;
// index 0 sets page_count (saturated to MAX_PAGES), index 1 sets burst_limit.
// A page ack passes through StAckRange and, if inside page_count, StAckRd, which sets
// its bitmap entry; every ack item then advances the contiguous pointer over acked
// entries in StScanCmp and StScanRd, and StAckOut registers its result.
// A burst request scans the bitmap from the contiguous pointer and registers its last
// result in StBEnd; the bitmap RAM is read one entry per step, with the single
// incrementer/comparator unit driving the scan. The block handles one item at a time
// and takes the next one in the cycle after the last result is registered.
// After reset and after every page_count write the bitmap is cleared in a pass over all
// MAX_PAGES entries, during which no item is accepted.
// The result register holds its transaction while the receiver stalls; the scan
// waits on it, and a new item can be accepted while the last result still waits.
module selective_repeat_sender_window_unit #(
  parameter int MAX_PAGES = 4096,
  parameter int BURST_MAX = 64,
  localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [srsw_pkg::CntW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  srsw_pkg::in_t             in_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output srsw_pkg::out_t            out_o
);

  localparam logic [16:0]               MaxPages = 17'(MAX_PAGES);
  localparam logic [srsw_pkg::LimW-1:0] BurstMax = srsw_pkg::LimW'(BURST_MAX);

  logic [srsw_pkg::CntW-1:0] page_count_q;
  logic [srsw_pkg::LimW-1:0] burst_limit_q;
  logic [srsw_pkg::CntW-1:0] pc_sat;
  srsw_pkg::cfg_t            cfg;
  srsw_pkg::alu_req_t        alu_req;
  srsw_pkg::alu_rsp_t        alu_rsp;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic                      ram_wdata;
  logic                      ram_re;
  logic [AW-1:0]             ram_raddr;
  logic [0:0]                ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign pc_sat = ({4'b0, cfg_data_i} > MaxPages) ? MaxPages[srsw_pkg::CntW-1:0] : cfg_data_i;

  always_comb begin
    cfg.page_count = page_count_q;
    cfg.burst_lim  = (burst_limit_q > BurstMax) ? BurstMax : burst_limit_q;
    cfg.pc_wr      = cfg_valid_i && (cfg_index_i == srsw_pkg::CfgPageCount);
    cfg.pc_wdata   = pc_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_count_q  <= '0;
      burst_limit_q <= srsw_pkg::LimW'(16);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        srsw_pkg::CfgPageCount:  page_count_q  <= pc_sat;
        srsw_pkg::CfgBurstLimit: burst_limit_q <= cfg_data_i[srsw_pkg::LimW-1:0];
        default: ;
      endcase
    end
  end

  srsw_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  srsw_ram #(
    .WIDTH (1),
    .DEPTH (MAX_PAGES)
  ) u_ack_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  srsw_seq #(
    .MAX_PAGES (MAX_PAGES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata[0])
  );

endmodule
